// ===== design/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV converter package
// Shared widths, constants and types of the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 15;
  localparam int unsigned SatW  = 16;

  localparam int unsigned DenW = ChanW;
  localparam int unsigned QuoW = 16;
  localparam int unsigned NumW = DenW + QuoW;

  localparam int unsigned DivStages       = 8;
  localparam int unsigned DivBitsPerStage = QuoW / DivStages;
  localparam int unsigned PipeStages      = DivStages + 2;

  localparam int unsigned HueQuoW   = 12;
  localparam int unsigned HuePadW   = QuoW - HueQuoW;
  localparam int unsigned HueProdW  = NumW - HuePadW;

  localparam logic [HueW-1:0] HueSixth = HueW'(3840);
  localparam logic [HueW-1:0] HueTurn  = HueW'(23040);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] val;
    sector_e          sector;
    logic             neg;
    logic             gray;
    logic             black;
  } side_t;

endpackage

`default_nettype wire

// ===== design/hsv_rgb_if.sv =====
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel carrying one 8-bit RGB pixel per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv_rgb_if;
  logic                      valid;
  logic                      ready;
  logic [hsv_pkg::ChanW-1:0] red_in;
  logic [hsv_pkg::ChanW-1:0] green_in;
  logic [hsv_pkg::ChanW-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

`default_nettype wire

// ===== design/hsv_res_if.sv =====
// ----------------------------------------------------------------------------
// HSV result channel
// Valid/ready channel carrying one hue, saturation and value triple.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv_res_if;
  logic                     valid;
  logic                     ready;
  logic [hsv_pkg::HueW-1:0]  hue_out;
  logic [hsv_pkg::SatW-1:0]  sat_out;
  logic [hsv_pkg::ChanW-1:0] val_out;

  modport source (output valid, output hue_out, output sat_out, output val_out,
                  input ready);
  modport sink (input valid, input hue_out, input sat_out, input val_out,
                output ready);
endinterface

`default_nettype wire

// ===== design/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one 8-bit RGB pixel per request into hue (1/64 degree units),
// saturation (Q0.16) and value (largest channel).
//
// Pixels arrive on the pix_i channel and results leave on the hsv_o channel,
// both valid/ready; a request is taken when valid and ready are both high.
// Results leave in the order the pixels arrived, one per pixel.
// An accepted pixel passes through these registered stages to its result:
// one stage finds the maximum, minimum and sector and forms both numerators,
// eight stages run two restoring divisions side by side at two quotient bits
// per stage, and a final stage applies the sector offset into the output
// register. A new pixel may be taken in every cycle that pix_i.ready is high.
// Each stage has its own valid bit and moves on when the next stage is empty
// or moving, so when the receiver stalls the pipeline fills its bubbles and
// pix_i.ready drops only once all ten stages hold a pixel; nothing is lost or
// repeated. Reset clears every valid bit, leaving the pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsv_rgb_if.sink   pix_i,
  hsv_res_if.source hsv_o
);

  localparam int unsigned ChanW = hsv_pkg::ChanW;
  localparam int unsigned HueW  = hsv_pkg::HueW;
  localparam int unsigned NumW  = hsv_pkg::NumW;
  localparam int unsigned Stg   = hsv_pkg::PipeStages;
  localparam int unsigned DStg  = hsv_pkg::DivStages;

  logic [Stg-1:0] v_q, v_d, rdy;

  always_comb begin
    rdy[Stg-1] = hsv_o.ready | ~v_q[Stg-1];
    for (int k = Stg - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
    for (int k = 0; k < Stg; k++) begin
      if (!rdy[k]) begin
        v_d[k] = v_q[k];
      end else if (k == 0) begin
        v_d[k] = pix_i.valid;
      end else begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign pix_i.ready = rdy[0];

  logic [ChanW-1:0]          mx, mn, delta, dmag, opa, opb;
  hsv_pkg::sector_e          sector;
  logic                      neg;
  logic [NumW-1:0]           sat_num_d, hue_num_d;
  logic [hsv_pkg::HueProdW-1:0] hue_prod;

  always_comb begin
    if (pix_i.red_in >= pix_i.green_in && pix_i.red_in >= pix_i.blue_in) begin
      sector = hsv_pkg::SEC_RED;
      mx     = pix_i.red_in;
      opa    = pix_i.green_in;
      opb    = pix_i.blue_in;
    end else if (pix_i.green_in >= pix_i.blue_in) begin
      sector = hsv_pkg::SEC_GREEN;
      mx     = pix_i.green_in;
      opa    = pix_i.blue_in;
      opb    = pix_i.red_in;
    end else begin
      sector = hsv_pkg::SEC_BLUE;
      mx     = pix_i.blue_in;
      opa    = pix_i.red_in;
      opb    = pix_i.green_in;
    end
    mn = (opa < opb) ? opa : opb;
    delta = mx - mn;
    if (opa >= opb) begin
      neg  = 1'b0;
      dmag = opa - opb;
    end else begin
      neg  = 1'b1;
      dmag = opb - opa;
    end
    sat_num_d = {delta, hsv_pkg::QuoW'(0)} - NumW'(delta);
    hue_prod  = {dmag, 12'd0} - {4'd0, dmag, 8'd0};
    hue_num_d = {hue_prod, hsv_pkg::HuePadW'(0)};
  end

  hsv_pkg::side_t side_q [Stg-1];
  hsv_pkg::side_t side_in;

  assign side_in = '{val: mx, sector: sector, neg: neg,
                     gray: (delta == '0), black: (mx == '0)};

  logic [NumW-1:0]  sat_num_q, hue_num_q;
  logic [ChanW-1:0] sat_den_q, hue_den_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sat_num_q <= sat_num_d;
      hue_num_q <= hue_num_d;
      sat_den_q <= mx;
      hue_den_q <= delta;
    end
  end

  for (genvar k = 0; k < Stg - 1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        side_q[k] <= (k == 0) ? side_in : side_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  logic [hsv_pkg::QuoW-1:0] sat_quo, hue_quo;

  hsv_div_pipe u_sat_div (
    .clk_i (clk_i),
    .en_i  (rdy[DStg:1]),
    .num_i (sat_num_q),
    .den_i (sat_den_q),
    .quo_o (sat_quo)
  );

  hsv_div_pipe u_hue_div (
    .clk_i (clk_i),
    .en_i  (rdy[DStg:1]),
    .num_i (hue_num_q),
    .den_i (hue_den_q),
    .quo_o (hue_quo)
  );

  hsv_pkg::side_t        fin;
  logic [HueW-1:0]       hq, base, hue_d;
  logic [hsv_pkg::SatW-1:0] sat_d;

  always_comb begin
    fin = side_q[Stg-2];
    hq  = HueW'(hue_quo[hsv_pkg::QuoW-1:hsv_pkg::HuePadW]);
    case (fin.sector)
      hsv_pkg::SEC_RED:   base = '0;
      hsv_pkg::SEC_GREEN: base = HueW'(2 * hsv_pkg::HueSixth);
      hsv_pkg::SEC_BLUE:  base = HueW'(4 * hsv_pkg::HueSixth);
      default:            base = '0;
    endcase
    if (fin.gray || hq == '0) begin
      hue_d = fin.gray ? '0 : base;
    end else if (fin.neg) begin
      hue_d = (fin.sector == hsv_pkg::SEC_RED) ? hsv_pkg::HueTurn - hq : base - hq;
    end else begin
      hue_d = base + hq;
    end
    sat_d = fin.black ? '0 : sat_quo;
  end

  logic [HueW-1:0]          hue_q;
  logic [hsv_pkg::SatW-1:0] sat_q;
  logic [ChanW-1:0]         val_q;

  always_ff @(posedge clk_i) begin
    if (rdy[Stg-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= fin.val;
    end
  end

  assign hsv_o.valid   = v_q[Stg-1];
  assign hsv_o.hue_out = hue_q;
  assign hsv_o.sat_out = sat_q;
  assign hsv_o.val_out = val_q;

endmodule

`default_nettype wire

// ===== design/hsv_div_pipe.sv =====
// ----------------------------------------------------------------------------
// HSV pipelined divider
// Restoring divider resolving a fixed number of quotient bits per stage.
// The numerator's top byte must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_div_pipe (
  input  logic                                clk_i,
  input  logic [hsv_pkg::DivStages-1:0]       en_i,
  input  logic [hsv_pkg::NumW-1:0]            num_i,
  input  logic [hsv_pkg::DenW-1:0]            den_i,
  output logic [hsv_pkg::QuoW-1:0]            quo_o
);

  localparam int unsigned DenW = hsv_pkg::DenW;
  localparam int unsigned QuoW = hsv_pkg::QuoW;
  localparam int unsigned Stg  = hsv_pkg::DivStages;
  localparam int unsigned Bps  = hsv_pkg::DivBitsPerStage;

  logic [DenW-1:0] rem_q [Stg];
  logic [QuoW-1:0] low_q [Stg];
  logic [QuoW-1:0] quo_q [Stg];
  logic [DenW-1:0] den_q [Stg];

  for (genvar s = 0; s < Stg; s++) begin : g_stage
    logic [DenW-1:0] rem_in, rem_d;
    logic [QuoW-1:0] low_in, low_d;
    logic [QuoW-1:0] quo_in, quo_d;
    logic [DenW-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = num_i[hsv_pkg::NumW-1:QuoW];
      assign low_in = num_i[QuoW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      logic [DenW:0] trial;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int b = 0; b < Bps; b++) begin
        trial = {rem_d, low_d[QuoW-1]};
        low_d = {low_d[QuoW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_d = DenW'(trial - {1'b0, den_in});
          quo_d = {quo_d[QuoW-2:0], 1'b1};
        end else begin
          rem_d = trial[DenW-1:0];
          quo_d = {quo_d[QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[Stg-1];

endmodule

`default_nettype wire
